FILE: hdl/pkcht_pkg.sv
// Shared types, constants and state encoding for the pid hash table.
package pkcht_pkg;

    // Table geometry.
    localparam int POOL_ENTRIES = 128;
    localparam int BUCKET_COUNT = 101;
    localparam int KEY_BITS     = 22;

    // Fixed field widths of the item interface.
    localparam int OP_W     = 1;
    localparam int PID_W    = 22;
    localparam int LINE_W   = 16;
    localparam int STATUS_W = 2;

    // Derived widths.
    localparam int NODE_W = $clog2(POOL_ENTRIES);
    localparam int USED_W = $clog2(POOL_ENTRIES + 1);
    localparam int BKT_W  = $clog2(BUCKET_COUNT);
    localparam int REM_W  = $clog2(2 * BUCKET_COUNT);
    localparam int HASH_W = 32;
    localparam int PROD_W = 2 * HASH_W;

    // Hash constants.
    localparam logic [HASH_W-1:0] HASH_SEED  = 32'd5381;
    localparam int                RADIX      = 10;
    localparam int                HASH_SHIFT = 5;
    localparam int                DIG_W      = $clog2(2 * RADIX);
    localparam int                DIGIT_W    = $clog2(RADIX);

    // Reciprocals, floor(2^32 / divisor); the quotient estimate is low by at most one.
    localparam logic [HASH_W-1:0] RECIP_RADIX  = HASH_W'((64'd1 << HASH_W) / RADIX);
    localparam logic [HASH_W-1:0] RECIP_BUCKET = HASH_W'((64'd1 << HASH_W) / BUCKET_COUNT);

    // Opcodes.
    localparam logic [OP_W-1:0] OP_LOOKUP = 1'b0;
    localparam logic [OP_W-1:0] OP_INSERT = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // One pool node as stored in the node memory.
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [LINE_W-1:0]   line;
        logic                link_valid;
        logic [NODE_W-1:0]   link;
    } node_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIG_MUL,
        S_DIG_ACC,
        S_MOD_SUB,
        S_MOD_FIX,
        S_HEAD_RD,
        S_WALK,
        S_CMP,
        S_HIT,
        S_MISS,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic dig_mul;
        logic dig_acc;
        logic mod_mul;
        logic mod_sub;
        logic mod_fix;
        logic head_rd;
        logic node_rd;
        logic node_next;
        logic hit;
        logic miss;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic key_zero;
        logic cur_valid;
        logic key_match;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/pid_keyed_chained_hash_table.sv
// Top level of the pid to line index hash table with chained buckets.
// Hashing steps through the decimal digits of the pid (up to 7) on the shared multiplier, then
// walks the bucket chain with registered node reads. One item at a time: the next is accepted
// only once the result of the last is loaded into the output register.
// Reset (aresetn low, synchronous) clears all bucket valid bits and the pool fill count at once.
module pid_keyed_chained_hash_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pid [21:0], line_index [37:22], zero [39:38]
    input  logic        s_tuser,   // opcode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status [1:0], stored_index [17:2], zero [23:18]
);
    import pkcht_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic [STATUS_W-1:0] out_status;
    logic [LINE_W-1:0]   out_index;

    // Sequencer.
    pkcht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hash, tables and result register.
    pkcht_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_opcode  (s_tuser),
        .in_pid     (s_tdata[PID_W-1:0]),
        .in_line    (s_tdata[PID_W +: LINE_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (out_status),
        .out_index  (out_index)
    );

    // Pack the result fields, status lowest.
    assign m_tdata = {6'd0, out_index, out_status};

endmodule

FILE: hdl/pkcht_ctrl.sv
// Controller state machine that sequences hashing, chain walk and update.
module pkcht_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  pkcht_pkg::sts_t  sts,
    output pkcht_pkg::cmd_t  cmd
);
    import pkcht_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DIG_MUL;
                end
            end
            S_DIG_MUL: begin
                // With no digits left, the multiplier starts the bucket reduction.
                if (sts.key_zero) begin
                    cmd.mod_mul = 1'b1;
                    state_next  = S_MOD_SUB;
                end else begin
                    cmd.dig_mul = 1'b1;
                    state_next  = S_DIG_ACC;
                end
            end
            S_DIG_ACC: begin
                cmd.dig_acc = 1'b1;
                state_next  = S_DIG_MUL;
            end
            S_MOD_SUB: begin
                cmd.mod_sub = 1'b1;
                state_next  = S_MOD_FIX;
            end
            S_MOD_FIX: begin
                cmd.mod_fix = 1'b1;
                state_next  = S_HEAD_RD;
            end
            S_HEAD_RD: begin
                cmd.head_rd = 1'b1;
                state_next  = S_WALK;
            end
            S_WALK: begin
                if (sts.cur_valid) begin
                    cmd.node_rd = 1'b1;
                    state_next  = S_CMP;
                end else begin
                    state_next = S_MISS;
                end
            end
            S_CMP: begin
                if (sts.key_match) begin
                    state_next = S_HIT;
                end else begin
                    cmd.node_next = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_HIT: begin
                cmd.hit    = 1'b1;
                state_next = S_OUT;
            end
            S_MISS: begin
                cmd.miss   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/pkcht_dpath.sv
// Datapath: digit hash, bucket reduction, table memories and result register.
module pkcht_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pkcht_pkg::cmd_t               cmd,
    output pkcht_pkg::sts_t               sts,
    input  logic [pkcht_pkg::OP_W-1:0]    in_opcode,
    input  logic [pkcht_pkg::PID_W-1:0]   in_pid,
    input  logic [pkcht_pkg::LINE_W-1:0]  in_line,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pkcht_pkg::STATUS_W-1:0] out_status,
    output logic [pkcht_pkg::LINE_W-1:0]  out_index
);
    import pkcht_pkg::*;

    // Captured item.
    logic [OP_W-1:0]     op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [LINE_W-1:0]   line_reg;

    // Hash state.
    logic [KEY_BITS-1:0] work_key_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [BKT_W-1:0]    bucket_reg;

    // Chain walk state.
    logic [NODE_W-1:0]   head_reg;
    logic                head_valid_reg;
    logic [NODE_W-1:0]   cur_reg;
    logic                cur_valid_reg;
    node_t               node_rd_reg;
    logic [USED_W-1:0]   used_reg;

    // Table storage.
    logic [BUCKET_COUNT-1:0] bvalid_reg;
    logic [NODE_W-1:0]       head_mem [BUCKET_COUNT];
    node_t                   node_mem [POOL_ENTRIES];

    // Result and output registers.
    logic [STATUS_W-1:0] res_status_reg;
    logic [LINE_W-1:0]   res_index_reg;
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [LINE_W-1:0]   m_index_reg;

    // Shared 32x32 multiplier: digit reciprocal or bucket reciprocal.
    logic [HASH_W-1:0] mul_a;
    logic [HASH_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;

    always_comb begin
        if (cmd.mod_mul) begin
            mul_a = hash_reg;
            mul_b = RECIP_BUCKET;
        end else begin
            mul_a = HASH_W'(work_key_reg);
            mul_b = RECIP_RADIX;
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Digit step: quotient estimate, remainder with one correction, hash update.
    logic [KEY_BITS-1:0] q_est;
    logic [KEY_BITS-1:0] dig_diff;
    logic [DIG_W-1:0]    dig_raw;
    logic [KEY_BITS-1:0] q_fix;
    logic [DIGIT_W-1:0]  digit;
    logic [HASH_W-1:0]   hash_step;

    always_comb begin
        q_est    = prod_reg[HASH_W +: KEY_BITS];
        dig_diff = work_key_reg - KEY_BITS'((q_est << 3) + (q_est << 1));
        dig_raw  = dig_diff[DIG_W-1:0];
        if (dig_raw >= DIG_W'(RADIX)) begin
            q_fix = q_est + KEY_BITS'(1);
            digit = DIGIT_W'(dig_raw - DIG_W'(RADIX));
        end else begin
            q_fix = q_est;
            digit = DIGIT_W'(dig_raw);
        end
        hash_step = (hash_reg << HASH_SHIFT) + hash_reg + HASH_W'(digit);
    end

    // Bucket reduction: remainder below twice the bucket count, then one correction.
    logic [HASH_W-1:0] hq_est;
    logic [HASH_W-1:0] mod_diff;
    logic [REM_W-1:0]  rem_fix;

    always_comb begin
        hq_est   = prod_reg[PROD_W-1:HASH_W];
        mod_diff = hash_reg - hq_est * HASH_W'(BUCKET_COUNT);
        if (rem_reg >= REM_W'(BUCKET_COUNT)) begin
            rem_fix = rem_reg - REM_W'(BUCKET_COUNT);
        end else begin
            rem_fix = rem_reg;
        end
    end

    // Item capture and hash registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg       <= in_opcode;
            key_reg      <= in_pid[KEY_BITS-1:0];
            line_reg     <= in_line;
            work_key_reg <= in_pid[KEY_BITS-1:0];
            hash_reg     <= HASH_SEED;
        end
        if (cmd.dig_mul || cmd.mod_mul) begin
            prod_reg <= mul_p;
        end
        if (cmd.dig_acc) begin
            work_key_reg <= q_fix;
            hash_reg     <= hash_step;
        end
        if (cmd.mod_sub) begin
            rem_reg <= mod_diff[REM_W-1:0];
        end
        if (cmd.mod_fix) begin
            bucket_reg <= BKT_W'(rem_fix);
        end
    end

    // Bucket head memory, read registered into both the saved head and the walk pointer.
    always_ff @(posedge aclk) begin
        if (cmd.head_rd) begin
            head_reg <= head_mem[bucket_reg];
            cur_reg  <= head_mem[bucket_reg];
        end else if (cmd.node_next) begin
            cur_reg <= node_rd_reg.link;
        end
        if (cmd.miss && op_reg == OP_INSERT && used_reg != USED_W'(POOL_ENTRIES)) begin
            head_mem[bucket_reg] <= used_reg[NODE_W-1:0];
        end
    end

    // Node memory: one read port for the walk, one write port for update or allocation.
    node_t node_wr;
    logic  node_we;
    logic [NODE_W-1:0] node_wa;

    always_comb begin
        node_wr = node_rd_reg;
        node_we = 1'b0;
        node_wa = cur_reg;
        if (cmd.hit && op_reg == OP_INSERT) begin
            node_we      = 1'b1;
            node_wr.line = line_reg;
        end else if (cmd.miss && op_reg == OP_INSERT && used_reg != USED_W'(POOL_ENTRIES)) begin
            node_we            = 1'b1;
            node_wa            = used_reg[NODE_W-1:0];
            node_wr.key        = key_reg;
            node_wr.line       = line_reg;
            node_wr.link_valid = head_valid_reg;
            node_wr.link       = head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.node_rd) begin
            node_rd_reg <= node_mem[cur_reg];
        end
        if (node_we) begin
            node_mem[node_wa] <= node_wr;
        end
    end

    // Control state: bucket valid bits, walk valid, pool fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bvalid_reg     <= '0;
            used_reg       <= '0;
            cur_valid_reg  <= 1'b0;
            head_valid_reg <= 1'b0;
        end else begin
            if (cmd.head_rd) begin
                head_valid_reg <= bvalid_reg[bucket_reg];
                cur_valid_reg  <= bvalid_reg[bucket_reg];
            end else if (cmd.node_next) begin
                cur_valid_reg <= node_rd_reg.link_valid;
            end
            if (cmd.miss && op_reg == OP_INSERT && used_reg != USED_W'(POOL_ENTRIES)) begin
                bvalid_reg[bucket_reg] <= 1'b1;
                used_reg               <= used_reg + USED_W'(1);
            end
        end
    end

    // Result of the finished operation.
    always_ff @(posedge aclk) begin
        if (cmd.hit) begin
            res_status_reg <= ST_FOUND;
            res_index_reg  <= (op_reg == OP_INSERT) ? line_reg : node_rd_reg.line;
        end else if (cmd.miss) begin
            if (op_reg == OP_LOOKUP) begin
                res_status_reg <= ST_MISSING;
                res_index_reg  <= '0;
            end else if (used_reg == USED_W'(POOL_ENTRIES)) begin
                res_status_reg <= ST_FULL;
                res_index_reg  <= '0;
            end else begin
                res_status_reg <= ST_NEW;
                res_index_reg  <= line_reg;
            end
        end
    end

    // Output register on the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= res_index_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign out_status = m_status_reg;
    assign out_index  = m_index_reg;

    // Status back to the controller.
    always_comb begin
        sts.key_zero  = (work_key_reg == '0);
        sts.cur_valid = cur_valid_reg;
        sts.key_match = (node_rd_reg.key == key_reg);
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    // The pool fill count never passes the pool size.
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= USED_W'(POOL_ENTRIES))
        else $error("pool fill count exceeds the pool size");

    // The remainder before correction stays below twice the bucket count.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mod_fix |-> rem_reg < REM_W'(2 * BUCKET_COUNT))
        else $error("bucket remainder out of range");

    // A corrected bucket index always names a real bucket.
    a_bucket_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.head_rd |-> bucket_reg < BKT_W'(BUCKET_COUNT))
        else $error("bucket index out of range");

    // The fill count moves only when a new node is reported.
    a_alloc_new: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.miss && op_reg == OP_INSERT && used_reg != USED_W'(POOL_ENTRIES)
        |=> res_status_reg == ST_NEW)
        else $error("node allocated without a new-insert result");

endmodule

FILE: bench/pid_keyed_chained_hash_table_tb.sv
// Self-checking testbench for the pid to line index chained hash table.
module pid_keyed_chained_hash_table_tb;
    import pkcht_pkg::*;

    localparam int RANDOM_ITEMS  = 650;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int IDLE_PERCENT  = 24;
    localparam int PRINT_LIMIT   = 50;

    // One reply of the block: status code and the line index held for the pid.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LINE_W-1:0]   index;
    } reply_t;

    // One directed row; the reply is typed in only where it is obvious.
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [PID_W-1:0]  pid;
        logic [LINE_W-1:0] line;
        bit                typed;
        reply_t            reply;
    } row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // pid [21:0], line_index [37:22], zero [39:38]
    logic        s_tuser  = 1'b0; // opcode [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // status [1:0], stored_index [17:2], zero [23:18]

    // Shadow copy of the table that predicts each reply.
    bit                  bkt_valid [BUCKET_COUNT];
    int unsigned         bkt_head  [BUCKET_COUNT];
    logic [KEY_BITS-1:0] nd_key    [POOL_ENTRIES];
    logic [LINE_W-1:0]   nd_line   [POOL_ENTRIES];
    bit                  nd_link_ok[POOL_ENTRIES];
    int unsigned         nd_link   [POOL_ENTRIES];
    int unsigned         nd_used = 0;

    reply_t      expected_replies[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          calm = 1'b0;

    pid_keyed_chained_hash_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock.
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Bucket of a pid: djb2 over the decimal digits, lowest digit first.
    function automatic int unsigned pid_bucket(logic [KEY_BITS-1:0] key);
        logic [HASH_W-1:0] h;
        int unsigned       k;
        h = HASH_SEED;
        k = key;
        while (k != 0) begin
            h = (h << HASH_SHIFT) + h + HASH_W'(k % RADIX);
            k = k / RADIX;
        end
        return h % BUCKET_COUNT;
    endfunction

    // First pid at or above a start value that falls into the given bucket.
    function automatic logic [PID_W-1:0] pid_in_bucket(int unsigned target,
                                                       logic [PID_W-1:0] from);
        logic [PID_W-1:0] p;
        p = from;
        while (pid_bucket(p[KEY_BITS-1:0]) != target) p++;
        return p;
    endfunction

    // Applies one item to the shadow table and returns the reply it causes.
    function automatic reply_t pid_table_apply(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                                               logic [LINE_W-1:0] line);
        reply_t              res;
        logic [KEY_BITS-1:0] key;
        int unsigned         b;
        int unsigned         cur;
        int unsigned         steps;
        int unsigned         hit_node;
        bit                  ok;
        bit                  hit;
        key      = pid[KEY_BITS-1:0];
        b        = pid_bucket(key);
        ok       = bkt_valid[b];
        cur      = bkt_head[b];
        steps    = 0;
        hit      = 1'b0;
        hit_node = 0;
        // Walk the chain, never more nodes than are allocated.
        while (ok && !hit && steps < nd_used && cur < POOL_ENTRIES) begin
            if (nd_key[cur] == key) begin
                hit      = 1'b1;
                hit_node = cur;
            end else begin
                ok    = nd_link_ok[cur];
                cur   = nd_link[cur];
                steps = steps + 1;
            end
        end
        res.index = '0;
        if (op == OP_LOOKUP) begin
            if (hit) begin
                res.status = ST_FOUND;
                res.index  = nd_line[hit_node];
            end else begin
                res.status = ST_MISSING;
            end
        end else if (hit) begin
            nd_line[hit_node] = line;
            res.status        = ST_FOUND;
            res.index         = line;
        end else if (nd_used >= POOL_ENTRIES) begin
            res.status = ST_FULL;
        end else begin
            // New node goes to the head of its chain.
            nd_key[nd_used]     = key;
            nd_line[nd_used]    = line;
            nd_link_ok[nd_used] = bkt_valid[b];
            nd_link[nd_used]    = bkt_head[b];
            bkt_valid[b]        = 1'b1;
            bkt_head[b]         = nd_used;
            nd_used             = nd_used + 1;
            res.status          = ST_NEW;
            res.index           = line;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        error_count++;
    endtask

    // Offers one item after a random gap; valid stays high into the next item if no gap.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                             input logic [LINE_W-1:0] line, input bit typed,
                             input reply_t typed_reply);
        reply_t predicted;
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, line, pid};
        do @(posedge aclk); while (!s_tready);
        predicted = pid_table_apply(op, pid, line);
        expected_replies.push_back(typed ? typed_reply : predicted);
    endtask

    // Holds the sender off until every expected reply has come back.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_replies.size() != 0);
    endtask

    // Receiver stalls at random, except during the calm stretch.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Compare every accepted reply with the oldest expectation.
    always @(posedge aclk) begin : check_reply
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("reply with nothing pending, status", m_tdata[1:0], 0);
            end else begin
                want = expected_replies.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", m_tdata[1:0], want.status);
                if (m_tdata[17:2] !== want.index)
                    report_mismatch("stored_index", m_tdata[17:2], want.index);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[pid_keyed_chained_hash_table] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        row_t             plan[$];
        logic [PID_W-1:0] seen_pids[$];
        logic [PID_W-1:0] c1, c2, c3, c4, pid;
        logic [LINE_W-1:0] line;
        logic [OP_W-1:0]  op;
        int unsigned      b0, pick, width;
        int unsigned      hot[3];
        int               n;

        // Pids that share the bucket of pid zero, for chain walks.
        b0 = pid_bucket('0);
        c1 = pid_in_bucket(b0, 22'd100);
        c2 = pid_in_bucket(b0, c1 + 1'b1);
        c3 = pid_in_bucket(b0, c2 + 1'b1);
        c4 = pid_in_bucket(b0, c3 + 1'b1);

        // Empty table, key extremes, updates, a chain of four and digit counts.
        plan.push_back('{OP_LOOKUP, 22'd0,       16'd0,      1, '{ST_MISSING, 16'd0}});
        plan.push_back('{OP_LOOKUP, 22'h3FFFFF,  16'hFFFF,   1, '{ST_MISSING, 16'd0}});
        plan.push_back('{OP_INSERT, 22'd0,       16'd0,      1, '{ST_NEW, 16'd0}});
        plan.push_back('{OP_INSERT, 22'h3FFFFF,  16'hFFFF,   1, '{ST_NEW, 16'hFFFF}});
        plan.push_back('{OP_LOOKUP, 22'd0,       16'hFFFF,   1, '{ST_FOUND, 16'd0}});
        plan.push_back('{OP_LOOKUP, 22'h3FFFFF,  16'd0,      1, '{ST_FOUND, 16'hFFFF}});
        plan.push_back('{OP_INSERT, 22'd0,       16'hFFFF,   1, '{ST_FOUND, 16'hFFFF}});
        plan.push_back('{OP_LOOKUP, 22'd0,       16'd0,      1, '{ST_FOUND, 16'hFFFF}});
        plan.push_back('{OP_INSERT, c1,          16'h5555,   1, '{ST_NEW, 16'h5555}});
        plan.push_back('{OP_INSERT, c2,          16'hAAAA,   1, '{ST_NEW, 16'hAAAA}});
        plan.push_back('{OP_INSERT, c3,          16'h0001,   1, '{ST_NEW, 16'h0001}});
        plan.push_back('{OP_LOOKUP, c1,          16'd0,      1, '{ST_FOUND, 16'h5555}});
        plan.push_back('{OP_LOOKUP, 22'd0,       16'd0,      1, '{ST_FOUND, 16'hFFFF}});
        plan.push_back('{OP_LOOKUP, c4,          16'd0,      1, '{ST_MISSING, 16'd0}});
        plan.push_back('{OP_INSERT, c2,          16'h8000,   1, '{ST_FOUND, 16'h8000}});
        plan.push_back('{OP_LOOKUP, c2,          16'd0,      1, '{ST_FOUND, 16'h8000}});
        plan.push_back('{OP_INSERT, 22'd1,       16'd1,      1, '{ST_NEW, 16'd1}});
        plan.push_back('{OP_INSERT, 22'd9,       16'h00FF,   1, '{ST_NEW, 16'h00FF}});
        plan.push_back('{OP_INSERT, 22'd10,      16'hFF00,   1, '{ST_NEW, 16'hFF00}});
        plan.push_back('{OP_INSERT, 22'd1000000, 16'h1234,   1, '{ST_NEW, 16'h1234}});
        plan.push_back('{OP_LOOKUP, 22'd1000000, 16'd0,      1, '{ST_FOUND, 16'h1234}});
        plan.push_back('{OP_LOOKUP, 22'd2,       16'd0,      1, '{ST_MISSING, 16'd0}});
        plan.push_back('{OP_LOOKUP, 22'd999999,  16'd0,      0, '{ST_FOUND, 16'd0}});
        plan.push_back('{OP_INSERT, 22'd3000000, 16'h7F7F,   0, '{ST_FOUND, 16'd0}});

        // Reset once.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows.
        foreach (plan[i]) begin
            send_item(plan[i].op, plan[i].pid, plan[i].line, plan[i].typed, plan[i].reply);
            if (plan[i].op == OP_INSERT) seen_pids.push_back(plan[i].pid);
        end
        drain_replies();

        // A few crowded buckets make long chains.
        hot[0] = b0;
        hot[1] = $urandom_range(0, BUCKET_COUNT - 1);
        hot[2] = $urandom_range(0, BUCKET_COUNT - 1);

        // Random items: fill the pool, then keep hitting it once it is full.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 150 && n < 300);
            if (n == 400) drain_replies();

            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                pid = seen_pids[$urandom_range(0, seen_pids.size() - 1)];
            end else if (pick < 65) begin
                pid = pid_in_bucket(hot[$urandom_range(0, 2)], PID_W'($urandom));
            end else if (pick < 80) begin
                pid = PID_W'($urandom_range(0, 999));
            end else begin
                width = $urandom_range(1, PID_W);
                pid   = PID_W'($urandom) & PID_W'((64'd1 << width) - 1);
            end

            if (nd_used < POOL_ENTRIES)
                op = ($urandom_range(0, 99) < 65) ? OP_INSERT : OP_LOOKUP;
            else
                op = ($urandom_range(0, 99) < 40) ? OP_INSERT : OP_LOOKUP;

            case ($urandom_range(0, 9))
                0: begin
                    line = '0;
                end
                1: begin
                    line = '1;
                end
                default: begin
                    line = LINE_W'($urandom);
                end
            endcase

            send_item(op, pid, line, 1'b0, '0);
            if (op == OP_INSERT) seen_pids.push_back(pid);
        end

        // Let the last replies arrive, then watch for strays.
        calm = 1'b0;
        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("[pid_keyed_chained_hash_table] OK");
        end else begin
            $display("[pid_keyed_chained_hash_table] ERROR");
        end
        $finish;
    end

endmodule
